### design/page_framebuffer_draw_engine_core_defines.svh
// ----------------------------------------------------------------------------
// Assertion macros for the page framebuffer draw engine
// Used by pfde_seq, which carries the concurrent checks.
// ----------------------------------------------------------------------------
`ifndef PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH
`define PAGE_FRAMEBUFFER_DRAW_ENGINE_CORE_DEFINES_SVH

// same-cycle implication, checked outside reset
`define PFDE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pfde assertion failed");

// next-cycle implication, checked outside reset
`define PFDE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pfde assertion failed");

`endif

### design/pfde_pkg.sv
// ----------------------------------------------------------------------------
// pfde_pkg
// Types and constants of the page framebuffer draw engine.
// ----------------------------------------------------------------------------
`default_nettype none

package pfde_pkg;

   localparam int COLUMNS_DEF = 128;
   localparam int PAGES_DEF   = 8;
   localparam int PAGE_BITS   = 8;     // pixel rows per page byte
   localparam int GLYPH_COLS  = 5;
   localparam int GLYPH_PITCH = 6;     // glyph plus gap column
   localparam int ADDR_MAX_W  = 12;    // covers 16 pages of 256 columns

   typedef enum logic [1:0] {
      ACT_CLEAR = 2'd0,
      ACT_FILL  = 2'd1,
      ACT_GLYPH = 2'd2,
      ACT_READ  = 2'd3
   } action_type;

   typedef struct packed {
      action_type action;
      logic [7:0] col_x;
      logic [7:0] row_y;
      logic [7:0] rect_width;
      logic [7:0] rect_height;
      logic [7:0] page_index;
      logic [7:0] glyph_col0;
      logic [7:0] glyph_col1;
      logic [7:0] glyph_col2;
      logic [7:0] glyph_col3;
      logic [7:0] glyph_col4;
   } req_type;

   typedef struct packed {
      logic [7:0] read_data;
      logic       status;
   } rsp_type;

   typedef struct packed {
      logic                  wr_en;
      logic [ADDR_MAX_W-1:0] wr_addr;
      logic [7:0]            wr_data;
      logic                  rd_en;
      logic [ADDR_MAX_W-1:0] rd_addr;
   } mem_req_type;

endpackage

`default_nettype wire

### design/page_framebuffer_draw_engine_core.sv
// ----------------------------------------------------------------------------
// page_framebuffer_draw_engine_core
// Monochrome page framebuffer with clear, fill, glyph and read commands.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_ready | pfde_pkg::req_type
//  rsp_    | out       | rsp_valid/rsp_ready | pfde_pkg::rsp_type
//
//  One request at a time; each command runs until its response is handed on.
//  Clear writes zero to every byte, one byte a cycle, then responds.
//  Fill read-modify-writes one covered byte a cycle, bound by the memory ports.
//  Glyph writes its five columns and read fetches one byte; a rejected or
//  empty request goes straight to its response. After reset the memory is
//  swept to zero with req_ready low. The response register lets the next
//  request in while a response still waits for rsp_ready.
// ----------------------------------------------------------------------------
`default_nettype none

module page_framebuffer_draw_engine_core #(
   parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
   parameter int PAGES   = pfde_pkg::PAGES_DEF
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_ready,
   input  wire pfde_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_ready,
   output pfde_pkg::rsp_type      rsp_data
);

   pfde_pkg::mem_req_type mem_req;
   logic [7:0]            rd_data;
   logic                  done_valid, done_ready;
   pfde_pkg::rsp_type     done_data;
   logic                  rsp_valid_ff;
   pfde_pkg::rsp_type     rsp_data_ff;

   pfde_store #(
      .DEPTH (COLUMNS * PAGES)
   ) u_store (
      .clock   (clock),
      .mem_req (mem_req),
      .rd_data (rd_data)
   );

   pfde_seq #(
      .COLUMNS (COLUMNS),
      .PAGES   (PAGES)
   ) u_seq (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .done_valid (done_valid),
      .done_ready (done_ready),
      .done_data  (done_data),
      .mem_req    (mem_req),
      .rd_data    (rd_data)
   );

   assign done_ready = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (done_ready) begin
         rsp_valid_ff <= done_valid;
      end
      if (done_valid && done_ready) begin
         rsp_data_ff <= done_data;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### design/pfde_store.sv
// ----------------------------------------------------------------------------
// pfde_store
// Framebuffer memory: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module pfde_store #(
   parameter int DEPTH = pfde_pkg::COLUMNS_DEF * pfde_pkg::PAGES_DEF
) (
   input  wire logic                  clock,
   input  wire pfde_pkg::mem_req_type mem_req,
   output logic [7:0]                 rd_data
);

   localparam int AW = $clog2(DEPTH);

   logic [7:0] mem [DEPTH];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (mem_req.wr_en) begin
         mem[mem_req.wr_addr[AW-1:0]] <= mem_req.wr_data;
      end
      if (mem_req.rd_en) begin
         rd_data_ff <= mem[mem_req.rd_addr[AW-1:0]];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

### design/pfde_seq.sv
// ----------------------------------------------------------------------------
// pfde_seq
// Command sequencer: clear sweep, fill read-modify-write walk, glyph writes
// and byte reads against the framebuffer memory.
// ----------------------------------------------------------------------------
`default_nettype none
`include "page_framebuffer_draw_engine_core_defines.svh"

module pfde_seq #(
   parameter int COLUMNS = pfde_pkg::COLUMNS_DEF,
   parameter int PAGES   = pfde_pkg::PAGES_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire pfde_pkg::req_type     req_data,
   output logic                       done_valid,
   input  wire logic                  done_ready,
   output pfde_pkg::rsp_type          done_data,
   output pfde_pkg::mem_req_type      mem_req,
   input  wire logic [7:0]            rd_data
);

   localparam int DEPTH = COLUMNS * PAGES;
   localparam int ROWS  = PAGES * pfde_pkg::PAGE_BITS;
   localparam int AW    = $clog2(DEPTH);
   localparam int CW    = $clog2(COLUMNS + 1);
   localparam int PW    = $clog2(PAGES + 1);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int GW    = $clog2(pfde_pkg::GLYPH_COLS);

   typedef enum logic [2:0] {
      S_SWEEP, S_IDLE, S_FILL, S_FLUSH, S_GLYPH, S_READ, S_RDWAIT, S_DONE
   } state_type;

   state_type         state_ff;
   logic [AW-1:0]     sweep_ff;
   logic              send_ff;
   logic [CW-1:0]     col_ff, col_lo_ff, col_hi_ff;
   logic [PW-1:0]     page_ff, page_hi_ff;
   logic [RW-1:0]     y_lo_ff, y_end_ff;
   logic              pend_ff;
   logic [AW-1:0]     pend_addr_ff;
   logic [7:0]        pend_mask_ff;
   logic [GW-1:0]     gk_ff;
   logic [AW-1:0]     base_ff;
   logic [7:0]        glyph_ff [pfde_pkg::GLYPH_COLS];
   pfde_pkg::rsp_type result_ff;

   logic              accept;
   logic [8:0]        x_sum, y_sum, x_end, y_end;
   logic              fill_empty;
   logic              glyph_bad, read_bad, req_bad;
   logic [AW-1:0]     req_addr, fill_addr;
   logic [7:0]        fill_mask;
   logic              fill_last;

   assign accept = req_valid && req_ready;

   // clip both edges; sums are nine bits so they never wrap
   always_comb begin
      x_sum = {1'b0, req_data.col_x} + {1'b0, req_data.rect_width};
      y_sum = {1'b0, req_data.row_y} + {1'b0, req_data.rect_height};
      x_end = (x_sum > 9'(COLUMNS)) ? 9'(COLUMNS) : x_sum;
      y_end = (y_sum > 9'(ROWS)) ? 9'(ROWS) : y_sum;
      fill_empty = (x_end <= {1'b0, req_data.col_x}) || (y_end <= {1'b0, req_data.row_y});
      glyph_bad = ({1'b0, req_data.page_index} >= 9'(PAGES)) ||
                  ({1'b0, req_data.col_x} > 9'(COLUMNS - pfde_pkg::GLYPH_PITCH));
      read_bad  = ({1'b0, req_data.page_index} >= 9'(PAGES)) ||
                  ({1'b0, req_data.col_x} >= 9'(COLUMNS));
      req_bad   = ((req_data.action == pfde_pkg::ACT_GLYPH) && glyph_bad) ||
                  ((req_data.action == pfde_pkg::ACT_READ) && read_bad);
      req_addr  = AW'(32'(req_data.page_index) * COLUMNS + 32'(req_data.col_x));
   end

   // address and row mask of the byte the fill walk is on
   always_comb begin
      int row;
      fill_addr = AW'(32'(page_ff) * COLUMNS + 32'(col_ff));
      for (int i = 0; i < pfde_pkg::PAGE_BITS; i++) begin
         row = int'(page_ff) * pfde_pkg::PAGE_BITS + i;
         fill_mask[i] = (row >= int'(y_lo_ff)) && (row < int'(y_end_ff));
      end
      fill_last = (col_ff == col_hi_ff) && (page_ff == page_hi_ff);
   end

   always_comb begin
      mem_req = '0;
      unique case (state_ff)
         S_SWEEP: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pfde_pkg::ADDR_MAX_W'(sweep_ff);
         end
         S_FILL, S_FLUSH: begin
            mem_req.wr_en   = pend_ff;
            mem_req.wr_addr = pfde_pkg::ADDR_MAX_W'(pend_addr_ff);
            mem_req.wr_data = rd_data | pend_mask_ff;
            mem_req.rd_en   = (state_ff == S_FILL);
            mem_req.rd_addr = pfde_pkg::ADDR_MAX_W'(fill_addr);
         end
         S_GLYPH: begin
            mem_req.wr_en   = 1'b1;
            mem_req.wr_addr = pfde_pkg::ADDR_MAX_W'(base_ff + AW'(gk_ff));
            mem_req.wr_data = glyph_ff[gk_ff];
         end
         S_READ: begin
            mem_req.rd_en   = 1'b1;
            mem_req.rd_addr = pfde_pkg::ADDR_MAX_W'(base_ff);
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_SWEEP;
         sweep_ff <= '0;
         send_ff  <= 1'b0;
         pend_ff  <= 1'b0;
      end else begin
         unique case (state_ff)
            S_SWEEP: begin
               if (sweep_ff == AW'(DEPTH - 1)) begin
                  sweep_ff <= '0;
                  state_ff <= send_ff ? S_DONE : S_IDLE;
               end else begin
                  sweep_ff <= sweep_ff + 1'b1;
               end
            end
            S_IDLE: begin
               if (accept) begin
                  result_ff <= '{read_data: 8'd0, status: req_bad};
                  pend_ff   <= 1'b0;
                  base_ff   <= req_addr;
                  gk_ff     <= '0;
                  glyph_ff[0] <= req_data.glyph_col0;
                  glyph_ff[1] <= req_data.glyph_col1;
                  glyph_ff[2] <= req_data.glyph_col2;
                  glyph_ff[3] <= req_data.glyph_col3;
                  glyph_ff[4] <= req_data.glyph_col4;
                  col_ff     <= CW'(req_data.col_x);
                  col_lo_ff  <= CW'(req_data.col_x);
                  col_hi_ff  <= CW'(x_end - 9'd1);
                  page_ff    <= PW'(req_data.row_y >> 3);
                  page_hi_ff <= PW'((y_end - 9'd1) >> 3);
                  y_lo_ff    <= RW'(req_data.row_y);
                  y_end_ff   <= RW'(y_end);
                  unique case (req_data.action)
                     pfde_pkg::ACT_CLEAR: begin
                        send_ff  <= 1'b1;
                        state_ff <= S_SWEEP;
                     end
                     pfde_pkg::ACT_FILL: begin
                        state_ff <= fill_empty ? S_DONE : S_FILL;
                     end
                     pfde_pkg::ACT_GLYPH: begin
                        state_ff <= glyph_bad ? S_DONE : S_GLYPH;
                     end
                     pfde_pkg::ACT_READ: begin
                        state_ff <= read_bad ? S_DONE : S_READ;
                     end
                     default: state_ff <= S_IDLE;
                  endcase
               end
            end
            S_FILL: begin
               pend_ff      <= 1'b1;
               pend_addr_ff <= fill_addr;
               pend_mask_ff <= fill_mask;
               if (fill_last) begin
                  state_ff <= S_FLUSH;
               end else if (col_ff == col_hi_ff) begin
                  col_ff  <= col_lo_ff;
                  page_ff <= page_ff + 1'b1;
               end else begin
                  col_ff <= col_ff + 1'b1;
               end
            end
            S_FLUSH: begin
               pend_ff  <= 1'b0;
               state_ff <= S_DONE;
            end
            S_GLYPH: begin
               if (gk_ff == GW'(pfde_pkg::GLYPH_COLS - 1)) begin
                  state_ff <= S_DONE;
               end else begin
                  gk_ff <= gk_ff + 1'b1;
               end
            end
            S_READ: begin
               state_ff <= S_RDWAIT;
            end
            S_RDWAIT: begin
               result_ff.read_data <= rd_data;
               state_ff <= S_DONE;
            end
            S_DONE: begin
               if (done_ready) begin
                  send_ff  <= 1'b0;
                  state_ff <= S_IDLE;
               end
            end
            default: state_ff <= S_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == S_IDLE);
   assign done_valid = (state_ff == S_DONE);
   assign done_data  = result_ff;

   // the fill walk never reads the byte it is writing back
   `PFDE_ASSERT_NOW(a_no_rw_clash, clock, reset,
      mem_req.wr_en && mem_req.rd_en, mem_req.wr_addr != mem_req.rd_addr)
   // nothing is written while a new request may come in
   `PFDE_ASSERT_NOW(a_idle_quiet, clock, reset, req_ready, !mem_req.wr_en && !mem_req.rd_en)
   // a held result stays put
   `PFDE_ASSERT_NEXT(a_done_hold, clock, reset,
      done_valid && !done_ready, done_valid && $stable(done_data))
   // a rejection never carries read data
   `PFDE_ASSERT_NOW(a_reject_zero, clock, reset,
      done_valid && done_data.status, done_data.read_data == 8'd0)

endmodule

`default_nettype wire
